@@ src/mfsk_ola_pkg.sv @@
package mfsk_ola_pkg;

  localparam int SYMBOL_LEN_DEF = 512;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;

  localparam logic [8:0] FIRST_CARRIER_RST      = 9'd64;
  localparam logic [6:0] CARRIER_SEPARATION_RST = 7'd4;
  localparam logic [9:0] SYMBOL_SEPARATION_RST  = 10'd256;
  localparam logic       USE_GRAY_CODE_RST      = 1'b1;
  localparam logic       PHASE_DIFFER_RST       = 1'b1;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned Q30_ONE    = 64'd1073741824;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SEND = 2'd1,
    OP_TAKE = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_CARRIER      = 3'd0,
    CFG_CARRIER_SEPARATION = 3'd1,
    CFG_SYMBOL_SEPARATION  = 3'd2,
    CFG_USE_GRAY_CODE      = 3'd3,
    CFG_PHASE_DIFFER       = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_STEP,
    BK_SETUP,
    BK_RUN,
    BK_DRAIN,
    BK_FINISH,
    BK_TAKE,
    BK_RESULT
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         symbol;
    logic               random_bit;
    logic [8:0]         window_index;
    logic signed [15:0] window_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_valid;
  } out_item_t;

  typedef struct packed {
    logic [8:0] first_carrier;
    logic [6:0] carrier_separation;
    logic [9:0] symbol_separation;
    logic       use_gray_code;
    logic       phase_differ;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        tone;
    logic               random_bit;
    logic [8:0]         window_index;
    logic signed [15:0] window_value;
  } cmd_t;

  function automatic longint unsigned div_small(input longint unsigned x,
                                                input longint unsigned d);
    longint unsigned q;
    case (d)
      64'd2:   q = x / 2;
      64'd3:   q = x / 3;
      64'd4:   q = x / 4;
      64'd5:   q = x / 5;
      64'd6:   q = x / 6;
      64'd7:   q = x / 7;
      64'd8:   q = x / 8;
      64'd9:   q = x / 9;
      64'd10:  q = x / 10;
      64'd11:  q = x / 11;
      64'd12:  q = x / 12;
      64'd13:  q = x / 13;
      64'd14:  q = x / 14;
      64'd15:  q = x / 15;
      64'd16:  q = x / 16;
      64'd17:  q = x / 17;
      64'd18:  q = x / 18;
      64'd19:  q = x / 19;
      64'd20:  q = x / 20;
      64'd21:  q = x / 21;
      64'd22:  q = x / 22;
      default: q = x;
    endcase
    return q;
  endfunction

  // First-quadrant cos (odd=0) or sin (odd=1) magnitude in Q15, 11-term Taylor in Q30.
  function automatic logic [15:0] rom_quarter(input int unsigned r,
                                              input int unsigned log_n,
                                              input bit odd);
    longint unsigned a;
    longint unsigned t;
    longint unsigned d;
    longint unsigned v;
    longint          s;
    a = (longint'(r) * TWO_PI_Q30) >> log_n;
    t = odd ? a : Q30_ONE;
    d = odd ? 64'd2 : 64'd1;
    s = longint'(t);
    for (int k = 0; k < 10; k++) begin
      t = div_small((t * a) >> 30, d);
      d = d + 1;
      t = div_small((t * a) >> 30, d);
      d = d + 1;
      if (k[0]) s = s + longint'(t);
      else      s = s - longint'(t);
    end
    if (s < 0) s = 0;
    v = (longint'(s) + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return 16'(v);
  endfunction

endpackage

@@ src/mfsk_ola_front.sv @@
module mfsk_ola_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  mfsk_ola_pkg::in_item_t                  in_item,
  input  logic                                    cfg_we,
  input  logic [mfsk_ola_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfsk_ola_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                    clearing,
  input  logic                                    q_full,
  output logic                                    q_push,
  output mfsk_ola_pkg::cmd_t                      q_data,
  output mfsk_ola_pkg::cfg_t                      cfg
);

  mfsk_ola_pkg::cfg_t cfg_r, cfg_nxt;
  logic [7:0]         sym_code;
  logic [15:0]        tone_step;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (mfsk_ola_pkg::cfg_idx_t'(cfg_index))
        mfsk_ola_pkg::CFG_FIRST_CARRIER:      cfg_nxt.first_carrier      = cfg_wdata[8:0];
        mfsk_ola_pkg::CFG_CARRIER_SEPARATION: cfg_nxt.carrier_separation = cfg_wdata[6:0];
        mfsk_ola_pkg::CFG_SYMBOL_SEPARATION:  cfg_nxt.symbol_separation  = cfg_wdata[9:0];
        mfsk_ola_pkg::CFG_USE_GRAY_CODE:      cfg_nxt.use_gray_code      = cfg_wdata[0];
        mfsk_ola_pkg::CFG_PHASE_DIFFER:       cfg_nxt.phase_differ       = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_carrier      <= mfsk_ola_pkg::FIRST_CARRIER_RST;
      cfg_r.carrier_separation <= mfsk_ola_pkg::CARRIER_SEPARATION_RST;
      cfg_r.symbol_separation  <= mfsk_ola_pkg::SYMBOL_SEPARATION_RST;
      cfg_r.use_gray_code      <= mfsk_ola_pkg::USE_GRAY_CODE_RST;
      cfg_r.phase_differ       <= mfsk_ola_pkg::PHASE_DIFFER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // symbol -> tone index
  always_comb begin
    sym_code  = cfg_r.use_gray_code ? (in_item.symbol ^ (in_item.symbol >> 1))
                                    : in_item.symbol;
    tone_step = {9'd0, cfg_r.carrier_separation} * {8'd0, sym_code};
    q_data.op           = mfsk_ola_pkg::op_t'(in_item.opcode);
    q_data.tone         = {7'd0, cfg_r.first_carrier} + tone_step;
    q_data.random_bit   = in_item.random_bit;
    q_data.window_index = in_item.window_index;
    q_data.window_value = in_item.window_value;
  end

  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;
  assign cfg      = cfg_r;

endmodule

@@ src/mfsk_ola_queue.sv @@
module mfsk_ola_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mfsk_ola_pkg::cmd_t push_data,
  output logic               full,
  input  logic               pop,
  output mfsk_ola_pkg::cmd_t pop_data,
  output logic               empty
);

  localparam int PW = $clog2(mfsk_ola_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mfsk_ola_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(mfsk_ola_pkg::QUEUE_DEPTH);

  mfsk_ola_pkg::cmd_t mem_r [mfsk_ola_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ src/mfsk_ola_back.sv @@
module mfsk_ola_back #(
  parameter int SYMBOL_LEN = mfsk_ola_pkg::SYMBOL_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mfsk_ola_pkg::cfg_t      cfg,
  input  logic                    q_empty,
  input  mfsk_ola_pkg::cmd_t      q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mfsk_ola_pkg::out_item_t out_item
);

  localparam int AW = $clog2(SYMBOL_LEN);
  localparam int QW = AW - 2;
  localparam int QN = SYMBOL_LEN / 4;
  localparam logic [AW-1:0] LAST   = {AW{1'b1}};
  localparam logic [AW-1:0] HALF_N = AW'(SYMBOL_LEN / 2);
  localparam logic [AW-1:0] QTR_N  = AW'(SYMBOL_LEN / 4);

  // quarter-wave cos/sin ROM
  logic [15:0] cos_tab [QN];
  logic [15:0] sin_tab [QN];

  for (genvar g = 0; g < QN; g++) begin : g_rom
    assign cos_tab[g] = mfsk_ola_pkg::rom_quarter(g, AW, 1'b0);
    assign sin_tab[g] = mfsk_ola_pkg::rom_quarter(g, AW, 1'b1);
  end

  logic signed [31:0] acc_mem [SYMBOL_LEN];
  logic signed [15:0] win_mem [SYMBOL_LEN];

  mfsk_ola_pkg::bk_state_t state_r, state_nxt;

  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [AW-1:0]           phase_r, phase_nxt;
  logic [AW-1:0]           step_r, step_nxt;
  logic [AW-1:0]           tone_r, tone_nxt;
  logic                    rbit_r, rbit_nxt;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           ph_r, ph_nxt;
  logic                    p1_r, p1_nxt;
  logic                    p2_r;
  logic [AW-1:0]           pos1_r, pos2_r;
  logic signed [16:0]      cos_r;
  logic signed [15:0]      win_rd_r;
  logic signed [31:0]      acc_rd_r, acc2_r;
  logic signed [32:0]      prod_r;
  mfsk_ola_pkg::out_item_t res_r, res_nxt;
  mfsk_ola_pkg::out_item_t out_r;
  logic                    out_valid_r;

  logic                    acc_we;
  logic [AW-1:0]           acc_waddr, acc_raddr;
  logic signed [31:0]      acc_wdata;
  logic                    win_we;
  logic [AW-1:0]           win_waddr;

  logic [15:0]             rom_mag;
  logic signed [16:0]      cos_val;
  logic signed [33:0]      sum;
  logic signed [31:0]      sat_sum;
  logic signed [32:0]      rnd;
  logic signed [32:0]      rnd_sh;
  logic signed [15:0]      sample_rnd;
  logic [AW-1:0]           half;
  logic [2*AW-1:0]         step_full;
  logic [AW-1:0]           jump;
  logic                    out_free;
  logic                    load_out;

  always_comb begin
    rom_mag = ph_r[AW-2] ? sin_tab[ph_r[QW-1:0]] : cos_tab[ph_r[QW-1:0]];
    cos_val = (ph_r[AW-1] ^ ph_r[AW-2]) ? -$signed({1'b0, rom_mag})
                                        : $signed({1'b0, rom_mag});
  end

  always_comb begin
    sum = 34'(acc2_r) + 34'(prod_r);
    if (sum > 34'sd2147483647)       sat_sum = 32'sh7FFFFFFF;
    else if (sum < -34'sd2147483648) sat_sum = 32'sh80000000;
    else                             sat_sum = sum[31:0];
  end

  always_comb begin
    rnd    = 33'(acc_rd_r) + 33'sd16384;
    rnd_sh = rnd >>> 15;
    if (rnd_sh > 33'sd32767)       sample_rnd = 16'sd32767;
    else if (rnd_sh < -33'sd32767) sample_rnd = -16'sd32767;
    else                           sample_rnd = rnd_sh[15:0];
  end

  always_comb begin
    half      = AW'(cfg.symbol_separation[9:1]) + HALF_N;
    step_full = (2*AW)'(tone_r) * (2*AW)'(half);
    if (!cfg.phase_differ) jump = '0;
    else if (rbit_r)       jump = -QTR_N;
    else                   jump = QTR_N;
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    tone_nxt  = tone_r;
    rbit_nxt  = rbit_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    ph_nxt    = ph_r;
    p1_nxt    = 1'b0;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    clearing  = 1'b0;
    load_out  = 1'b0;
    acc_we    = p2_r;
    acc_waddr = pos2_r;
    acc_wdata = sat_sum;
    acc_raddr = ptr_r;
    win_we    = 1'b0;
    win_waddr = AW'(q_data.window_index);

    unique case (state_r)
      mfsk_ola_pkg::BK_CLEAR: begin
        clearing  = 1'b1;
        acc_we    = 1'b1;
        acc_waddr = cnt_r;
        acc_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = mfsk_ola_pkg::BK_IDLE;
      end
      mfsk_ola_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          res_nxt = '0;
          unique case (q_data.op)
            mfsk_ola_pkg::OP_LOAD: begin
              win_we    = 1'b1;
              state_nxt = mfsk_ola_pkg::BK_RESULT;
            end
            mfsk_ola_pkg::OP_SEND: begin
              tone_nxt  = AW'(q_data.tone);
              rbit_nxt  = q_data.random_bit;
              state_nxt = mfsk_ola_pkg::BK_STEP;
            end
            mfsk_ola_pkg::OP_TAKE: state_nxt = mfsk_ola_pkg::BK_TAKE;
            default:               state_nxt = mfsk_ola_pkg::BK_RESULT;
          endcase
        end
      end
      mfsk_ola_pkg::BK_STEP: begin
        step_nxt  = step_full[AW-1:0];
        state_nxt = mfsk_ola_pkg::BK_SETUP;
      end
      mfsk_ola_pkg::BK_SETUP: begin
        phase_nxt = phase_r + step_r;
        ph_nxt    = phase_r + step_r;
        pos_nxt   = ptr_r;
        cnt_nxt   = '0;
        state_nxt = mfsk_ola_pkg::BK_RUN;
      end
      mfsk_ola_pkg::BK_RUN: begin
        p1_nxt    = 1'b1;
        acc_raddr = pos_r;
        ph_nxt    = ph_r + tone_r;
        pos_nxt   = pos_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = mfsk_ola_pkg::BK_DRAIN;
      end
      mfsk_ola_pkg::BK_DRAIN: begin
        if (!p1_r && !p2_r) state_nxt = mfsk_ola_pkg::BK_FINISH;
      end
      mfsk_ola_pkg::BK_FINISH: begin
        phase_nxt = phase_r + step_r + jump;
        state_nxt = mfsk_ola_pkg::BK_RESULT;
      end
      mfsk_ola_pkg::BK_TAKE: begin
        acc_we               = 1'b1;
        acc_waddr            = ptr_r;
        acc_wdata            = '0;
        res_nxt.sample       = sample_rnd;
        res_nxt.sample_valid = 1'b1;
        ptr_nxt              = ptr_r + 1'b1;
        state_nxt            = mfsk_ola_pkg::BK_RESULT;
      end
      mfsk_ola_pkg::BK_RESULT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = mfsk_ola_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mfsk_ola_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfsk_ola_pkg::BK_CLEAR;
      ptr_r       <= '0;
      phase_r     <= '0;
      cnt_r       <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p1_r;
      out_valid_r <= load_out | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    tone_r   <= tone_nxt;
    rbit_r   <= rbit_nxt;
    pos_r    <= pos_nxt;
    ph_r     <= ph_nxt;
    res_r    <= res_nxt;
    cos_r    <= cos_val;
    pos1_r   <= pos_r;
    pos2_r   <= pos1_r;
    acc2_r   <= acc_rd_r;
    prod_r   <= 33'(cos_r) * 33'(win_rd_r);
    if (load_out) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= q_data.window_value;
    win_rd_r <= win_mem[cnt_r];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ src/mfsk_symbol_overlap_add_modulator.sv @@
// Path: the engine pops an accepted item from the queue in BK_IDLE and raises out_valid from
// BK_RESULT; a take passes BK_TAKE, a send BK_STEP, BK_SETUP, BK_RUN, BK_DRAIN and BK_FINISH.
// The engine holds one item at a time; a send keeps it busy for the read-modify-write sweep
// over the one-read one-write accumulator ring.
// Reset: synchronous; a BK_CLEAR pass then zeroes the accumulator ring, input stalled.
// Config registers return to their defaults; window entries stay undefined until loaded.
module mfsk_symbol_overlap_add_modulator #(
  parameter int SYMBOL_LEN = mfsk_ola_pkg::SYMBOL_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mfsk_ola_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mfsk_ola_pkg::out_item_t             out_item,
  input  logic                                cfg_we,
  input  logic [mfsk_ola_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfsk_ola_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mfsk_ola_pkg::cfg_t cfg;
  mfsk_ola_pkg::cmd_t push_cmd;
  mfsk_ola_pkg::cmd_t head_cmd;
  logic               q_push, q_full, q_pop, q_empty, clearing;

  mfsk_ola_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_cmd),
    .cfg       (cfg)
  );

  mfsk_ola_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  mfsk_ola_back #(
    .SYMBOL_LEN (SYMBOL_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (head_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
